@@ hdl/pdts_pkg.sv @@
// Package: shared types and constants of the priority delay task scheduler.
package pdts_pkg;

    localparam int NUM_TASKS_DEF  = 16;
    localparam int COUNT_BITS_DEF = 16;

    typedef enum logic [3:0] {
        ACT_TICK    = 4'd0,
        ACT_CREATE  = 4'd1,
        ACT_DELETE  = 4'd2,
        ACT_SUSPEND = 4'd3,
        ACT_RESUME  = 4'd4,
        ACT_SETPRIO = 4'd5,
        ACT_SETDLY  = 4'd6,
        ACT_NEXT    = 4'd7,
        ACT_DONE    = 4'd8
    } t_action;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_EMPTY   = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;
    localparam logic [1:0] ST_NONE    = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SINGLE,
        S_SHOW,
        S_OUT
    } t_state;

endpackage

@@ hdl/priority_delay_task_scheduler.sv @@
// Top level: task slot table, shared slot update unit and result register.
//
// Usage: one request transaction on the input channel (i_valid/o_ready)
// carries an action and its operands; exactly one result transaction leaves
// on the output channel (o_valid/i_ready). The block takes one request at
// a time: o_ready is high only while idle.
// Tick and next walk all NUM_TASKS slots through one shared compare/decrement
// unit, one slot per cycle, then pass through the show and output states.
// Every other action touches one slot and passes through the single, show
// and output states. A new request is taken the cycle after the result is
// accepted, when the sequencer has returned to idle.
// Reset (i_rst_n low, synchronous) clears all slot flags; priority, delay,
// countdown and run time fields hold garbage until a create writes them.
// When the receiver stalls, the result holds in the output register and no
// new request is taken until it leaves.
module priority_delay_task_scheduler #(
    parameter int NUM_TASKS  = pdts_pkg::NUM_TASKS_DEF,
    parameter int COUNT_BITS = pdts_pkg::COUNT_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [3:0]  i_action,
    input  logic [3:0]  i_slot,
    input  logic [7:0]  i_prio_value,
    input  logic        i_make_static,
    input  logic [15:0] i_delay_ticks,
    input  logic [15:0] i_elapsed_ticks,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [3:0]  o_task_id,
    output logic [7:0]  o_task_prio,
    output logic        o_task_active,
    output logic        o_task_ready,
    output logic        o_task_static,
    output logic [15:0] o_task_max_run
);
    localparam int IB = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

    pdts_pkg::t_state w_state;
    logic [IB-1:0]    w_idx;
    logic             w_last;
    logic             w_start;

    // flags
    logic [NUM_TASKS-1:0] r_valid, r_static, r_active, r_rdy;
    // payload stores
    logic [7:0]            r_prio   [NUM_TASKS];
    logic [COUNT_BITS-1:0] r_reload [NUM_TASKS];
    logic [COUNT_BITS-1:0] r_cnt    [NUM_TASKS];
    logic [15:0]           r_maxrun [NUM_TASKS];

    // latched request
    logic [3:0]            r_act;
    logic [3:0]            r_slot;
    logic [7:0]            r_pv;
    logic                  r_mks;
    logic [COUNT_BITS-1:0] r_dly;
    logic [COUNT_BITS-1:0] r_ela;

    // scan results
    logic          r_found;
    logic [IB-1:0] r_best;
    logic [7:0]    r_bprio;

    // result
    logic [1:0]  r_status;
    logic [3:0]  r_id;
    logic        r_show;

    assign o_ready = (w_state == pdts_pkg::S_IDLE);
    assign w_start = i_valid && o_ready;
    assign o_valid = (w_state == pdts_pkg::S_OUT);

    pdts_ctrl #(.NUM_TASKS(NUM_TASKS), .IDX_BITS(IB)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_scan     (i_action == pdts_pkg::ACT_TICK || i_action == pdts_pkg::ACT_NEXT),
        .i_out_ready(i_ready),
        .o_state    (w_state),
        .o_idx      (w_idx),
        .o_last     (w_last)
    );

    // single-slot decode
    logic          w_inrange;
    logic [IB-1:0] w_s;
    logic          w_sv;
    assign w_inrange = ({28'd0, r_slot} < 32'(NUM_TASKS));
    assign w_s       = IB'(r_slot);
    assign w_sv      = w_inrange && r_valid[w_s];

    // shared unit operand: scanned slot or addressed slot
    logic [IB-1:0]         w_u;
    logic [COUNT_BITS-1:0] w_cdec;
    assign w_u    = (w_state == pdts_pkg::S_SCAN) ? w_idx : w_s;
    assign w_cdec = (r_cnt[w_u] != '0) ? r_cnt[w_u] - 1'b1 : r_cnt[w_u];

    // latch request
    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_act  <= i_action;
            r_slot <= i_slot;
            r_pv   <= i_prio_value;
            r_mks  <= i_make_static;
            r_dly  <= COUNT_BITS'(i_delay_ticks);
            r_ela  <= COUNT_BITS'(i_elapsed_ticks);
        end
    end

    // flag updates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_static <= '0;
            r_active <= '0;
            r_rdy    <= '0;
            r_found  <= 1'b0;
        end else begin
            if (w_start) r_found <= 1'b0;
            if (w_state == pdts_pkg::S_SCAN && r_valid[w_u]) begin
                if (r_act == pdts_pkg::ACT_TICK) begin
                    if (r_active[w_u] && !r_rdy[w_u] && w_cdec == '0)
                        r_rdy[w_u] <= 1'b1;
                end else if (r_rdy[w_u]) begin
                    if (!r_active[w_u]) begin
                        r_rdy[w_u] <= 1'b0;
                    end else if (!r_found || r_prio[w_u] < r_bprio) begin
                        r_found <= 1'b1;
                    end
                end
            end
            if (w_state == pdts_pkg::S_SINGLE && w_inrange) begin
                case (r_act)
                    pdts_pkg::ACT_CREATE: if (!r_valid[w_s]) begin
                        r_valid[w_s]  <= 1'b1;
                        r_static[w_s] <= r_mks;
                        r_active[w_s] <= 1'b1;
                        r_rdy[w_s]    <= 1'b0;
                    end
                    pdts_pkg::ACT_DELETE: if (w_sv) begin
                        r_active[w_s] <= 1'b0;
                        if (!r_static[w_s]) begin
                            r_valid[w_s]  <= 1'b0;
                            r_static[w_s] <= 1'b0;
                            r_rdy[w_s]    <= 1'b0;
                        end
                    end
                    pdts_pkg::ACT_SUSPEND: if (w_sv) r_active[w_s] <= 1'b0;
                    pdts_pkg::ACT_RESUME:  if (w_sv) r_active[w_s] <= 1'b1;
                    pdts_pkg::ACT_DONE:    if (w_sv) r_rdy[w_s] <= 1'b0;
                    default: ;
                endcase
            end
        end
    end

    // payload updates and best-candidate tracking
    always_ff @(posedge i_clk) begin
        if (w_state == pdts_pkg::S_SCAN && r_valid[w_u]) begin
            if (r_act == pdts_pkg::ACT_TICK) begin
                if (r_active[w_u] && !r_rdy[w_u]) r_cnt[w_u] <= w_cdec;
            end else if (r_rdy[w_u]) begin
                if (!r_active[w_u]) begin
                    r_cnt[w_u] <= r_reload[w_u];
                end else if (!r_found || r_prio[w_u] < r_bprio) begin
                    r_best  <= w_u;
                    r_bprio <= r_prio[w_u];
                end
            end
        end
        if (w_state == pdts_pkg::S_SINGLE && w_inrange) begin
            case (r_act)
                pdts_pkg::ACT_CREATE: if (!r_valid[w_s]) begin
                    r_prio[w_s]   <= r_pv;
                    r_reload[w_s] <= '0;
                    r_cnt[w_s]    <= '0;
                    r_maxrun[w_s] <= '0;
                end
                pdts_pkg::ACT_SETPRIO: if (w_sv) r_prio[w_s] <= r_pv;
                pdts_pkg::ACT_SETDLY: if (w_sv) begin
                    r_reload[w_s] <= r_dly;
                    r_cnt[w_s]    <= r_dly;
                end
                pdts_pkg::ACT_DONE: if (w_sv && r_rdy[w_s]) begin
                    if (16'(r_ela) > r_maxrun[w_s]) r_maxrun[w_s] <= 16'(r_ela);
                    r_cnt[w_s] <= r_reload[w_s];
                end
                default: ;
            endcase
        end
    end

    // decide status and shown slot
    always_ff @(posedge i_clk) begin
        if (w_state == pdts_pkg::S_SINGLE) begin
            r_id   <= r_slot;
            r_show <= 1'b1;
            if (r_act > pdts_pkg::ACT_DONE || !w_inrange) begin
                r_status <= pdts_pkg::ST_INVALID;
                r_show   <= 1'b0;
            end else if (r_act == pdts_pkg::ACT_CREATE) begin
                r_status <= r_valid[w_s] ? pdts_pkg::ST_INVALID : pdts_pkg::ST_OK;
            end else if (!r_valid[w_s]) begin
                r_status <= pdts_pkg::ST_EMPTY;
                r_show   <= 1'b0;
            end else if (r_act == pdts_pkg::ACT_DELETE && r_static[w_s]) begin
                r_status <= pdts_pkg::ST_INVALID;
            end else if (r_act == pdts_pkg::ACT_DONE && !r_rdy[w_s]) begin
                r_status <= pdts_pkg::ST_INVALID;
            end else begin
                r_status <= pdts_pkg::ST_OK;
            end
        end else if (w_state == pdts_pkg::S_SCAN && w_last) begin
            r_status <= pdts_pkg::ST_OK;
            r_id     <= '0;
            r_show   <= 1'b0;
        end else if (w_state == pdts_pkg::S_SHOW && r_act == pdts_pkg::ACT_NEXT) begin
            r_status <= r_found ? pdts_pkg::ST_OK : pdts_pkg::ST_NONE;
            r_id     <= r_found ? 4'(r_best) : 4'd0;
            r_show   <= r_found;
        end
    end

    // read the shown slot after the update has landed
    logic [IB-1:0] w_r;
    logic          w_rv;
    assign w_r  = IB'(r_id);
    assign w_rv = r_show && ({28'd0, r_id} < 32'(NUM_TASKS)) && r_valid[w_r];

    // output fields from the settled table, zero when no slot is shown
    assign o_status       = r_status;
    assign o_task_id      = r_id;
    assign o_task_prio    = w_rv ? r_prio[w_r] : 8'd0;
    assign o_task_active  = w_rv ? r_active[w_r] : 1'b0;
    assign o_task_ready   = w_rv ? r_rdy[w_r] : 1'b0;
    assign o_task_static  = w_rv ? r_static[w_r] : 1'b0;
    assign o_task_max_run = w_rv ? r_maxrun[w_r] : 16'd0;

`ifndef SYNTH
    // a result is offered only when no request can be taken
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_valid && o_ready)) else $error("result and request overlap");
    // a stalled result holds its status
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status))
        else $error("result dropped under stall");
    // a taken request leads to work, not idle
    a_go: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready) else $error("request lost");
`endif
endmodule

@@ hdl/pdts_ctrl.sv @@
// Sequencer: state register and scan counter.
module pdts_ctrl #(
    parameter int NUM_TASKS = pdts_pkg::NUM_TASKS_DEF,
    parameter int IDX_BITS  = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic                 i_scan,
    input  logic                 i_out_ready,
    output pdts_pkg::t_state     o_state,
    output logic [IDX_BITS-1:0]  o_idx,
    output logic                 o_last
);
    pdts_pkg::t_state r_state, n_state;
    logic [IDX_BITS-1:0] r_idx, n_idx;

    assign o_last  = (r_idx == IDX_BITS'(NUM_TASKS - 1));
    assign o_state = r_state;
    assign o_idx   = r_idx;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            pdts_pkg::S_IDLE:   if (i_start) n_state = i_scan ? pdts_pkg::S_SCAN
                                                              : pdts_pkg::S_SINGLE;
            pdts_pkg::S_SCAN:   if (o_last) n_state = pdts_pkg::S_SHOW;
            pdts_pkg::S_SINGLE: n_state = pdts_pkg::S_SHOW;
            pdts_pkg::S_SHOW:   n_state = pdts_pkg::S_OUT;
            pdts_pkg::S_OUT:    if (i_out_ready) n_state = pdts_pkg::S_IDLE;
            default:            n_state = pdts_pkg::S_IDLE;
        endcase
    end

    // scan index
    always_comb begin
        case (r_state)
            pdts_pkg::S_SCAN: n_idx = r_idx + 1'b1;
            default:          n_idx = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pdts_pkg::S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end
endmodule
